>>> sv/hct_pkg.sv
// Package for the heap chunk tracker: table size, status and command codes,
// item and entry types, and the entry match function.
// Used by the top level and the checker; depends on nothing.
package hct_pkg;

   localparam int TABLE_ENTRIES = 1024;
   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

   // Operation ids at or above this value are refused.
   localparam logic [63:0] OID_LIMIT = 64'hFFFF_FFFF_FFFF_FFF0;

   typedef enum logic {
      CMD_ALLOC   = 1'b0,
      CMD_RELEASE = 1'b1
   } command_type;

   typedef enum logic [2:0] {
      STATUS_OK          = 3'd0,
      STATUS_LIVE_REUSED = 3'd1,
      STATUS_TABLE_FULL  = 3'd2,
      STATUS_NOT_CHUNK   = 3'd3,
      STATUS_INTERIOR    = 3'd4,
      STATUS_DOUBLE_FREE = 3'd5,
      STATUS_OVERFLOW    = 3'd6
   } status_type;

   typedef enum logic [2:0] {
      FSM_IDLE,
      FSM_START,
      FSM_SCAN,
      FSM_DECIDE,
      FSM_FINISH
   } fsm_type;

   typedef struct packed {
      command_type command;
      logic [63:0] address;
      logic [63:0] size;
   } req_type;

   typedef struct packed {
      logic [63:0] op_id;
      status_type  status;
      logic        zero_size_warning;
      logic [63:0] earlier_alloc_op;
      logic [63:0] earlier_free_op;
      logic [63:0] alloc_total;
      logic [63:0] release_total;
   } rsp_type;

   // One table entry. Entries below the fill count are in use; freed tells
   // a released chunk from a live one.
   typedef struct packed {
      logic        freed;
      logic [63:0] base;
      logic [63:0] length;
      logic [63:0] alloc_id;
      logic [63:0] release_id;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // An allocation matches on an equal base; a release matches when the
   // address lies in the inclusive range starting at the base.
   function automatic logic entry_matches(command_type cmd, logic [63:0] addr,
                                          entry_type entry);
      logic [63:0] offset;
      offset = addr - entry.base;
      if (cmd == CMD_ALLOC) begin
         return addr == entry.base;
      end
      return (addr >= entry.base) && (offset <= entry.length);
   endfunction

endpackage

>>> sv/heap_chunk_tracker.sv
// Top level of the heap chunk tracker: sequencer, counters and result register.
// Depends on hct_pkg and hct_ram.
//
// The req channel carries one event item (allocation or release) and the rsp
// channel returns exactly one result item for it; both use valid/ready.
// An item is taken only while the block is idle. It then runs a scan over
// the used table entries, one entry per cycle through the single read port
// of the entry memory, stops at the first match, and updates at most one entry.
// An overflowing id or an empty table skips the scan. The next item is
// accepted in the cycle after the result is loaded.
// A result waits in the output register while rsp_ready is low; the block
// still accepts and processes the next item, and holds that item's result
// until the output register is free.
// Reset clears the counters and the fill count. Entries are taken in order
// and never return to unused, so the fill count alone marks the used
// entries and the memory needs no clearing pass after reset.
module heap_chunk_tracker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  hct_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output hct_pkg::rsp_type rsp_data
);

   hct_pkg::fsm_type              state_ff, state_in;
   logic [63:0]                   alloc_count_ff, alloc_count_in;
   logic [63:0]                   release_count_ff, release_count_in;
   logic [hct_pkg::CNT_W-1:0]     fill_ff, fill_in;
   logic [hct_pkg::CNT_W-1:0]     scan_idx_ff, scan_idx_in;
   logic                          chk_valid_ff, chk_valid_in;
   logic [hct_pkg::IDX_W-1:0]     chk_idx_ff, chk_idx_in;
   logic                          rsp_valid_ff, rsp_valid_in;

   hct_pkg::req_type              req_ff, req_in;
   logic [63:0]                   op_id_ff, op_id_in;
   logic                          ovf_ff, ovf_in;
   logic                          hit_ff, hit_in;
   logic [hct_pkg::IDX_W-1:0]     hit_idx_ff, hit_idx_in;
   hct_pkg::entry_type            hit_entry_ff, hit_entry_in;
   hct_pkg::rsp_type              res_ff, res_in;
   hct_pkg::rsp_type              rsp_data_ff, rsp_data_in;

   logic                          ram_rd_en;
   logic [hct_pkg::IDX_W-1:0]     ram_rd_addr;
   logic [hct_pkg::ENTRY_W-1:0]   ram_rd_data;
   logic                          ram_wr_en;
   logic [hct_pkg::IDX_W-1:0]     ram_wr_addr;
   hct_pkg::entry_type            ram_wr_entry;
   hct_pkg::entry_type            rd_entry;
   logic                          issue;
   logic                          table_full;

   hct_ram #(
      .WIDTH (hct_pkg::ENTRY_W),
      .DEPTH (hct_pkg::TABLE_ENTRIES),
      .AW    (hct_pkg::IDX_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_entry),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rd_entry   = hct_pkg::entry_type'(ram_rd_data);
   assign table_full = fill_ff == hct_pkg::CNT_W'(hct_pkg::TABLE_ENTRIES);
   assign issue      = (state_ff == hct_pkg::FSM_SCAN) && (scan_idx_ff < fill_ff);

   assign req_ready = state_ff == hct_pkg::FSM_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      state_in         = state_ff;
      alloc_count_in   = alloc_count_ff;
      release_count_in = release_count_ff;
      fill_in          = fill_ff;
      scan_idx_in      = scan_idx_ff;
      chk_valid_in     = 1'b0;
      chk_idx_in       = scan_idx_ff[hct_pkg::IDX_W-1:0];
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      req_in           = req_ff;
      op_id_in         = op_id_ff;
      ovf_in           = ovf_ff;
      hit_in           = hit_ff;
      hit_idx_in       = hit_idx_ff;
      hit_entry_in     = hit_entry_ff;
      res_in           = res_ff;
      rsp_data_in      = rsp_data_ff;
      ram_rd_en        = 1'b0;
      ram_rd_addr      = scan_idx_ff[hct_pkg::IDX_W-1:0];
      ram_wr_en        = 1'b0;
      ram_wr_addr      = hit_idx_ff;
      ram_wr_entry     = hit_entry_ff;

      unique case (state_ff)
         hct_pkg::FSM_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               op_id_in = alloc_count_ff + release_count_ff + 64'd1;
               state_in = hct_pkg::FSM_START;
            end
         end

         hct_pkg::FSM_START: begin
            ovf_in      = op_id_ff >= hct_pkg::OID_LIMIT;
            hit_in      = 1'b0;
            scan_idx_in = '0;
            if (ovf_in || (fill_ff == '0)) begin
               state_in = hct_pkg::FSM_DECIDE;
            end else begin
               state_in = hct_pkg::FSM_SCAN;
            end
         end

         hct_pkg::FSM_SCAN: begin
            // Reads are issued one entry ahead of the compare.
            ram_rd_en    = issue;
            chk_valid_in = issue;
            if (issue) begin
               scan_idx_in = scan_idx_ff + hct_pkg::CNT_W'(1);
            end
            if (chk_valid_ff &&
                hct_pkg::entry_matches(req_ff.command, req_ff.address, rd_entry)) begin
               hit_in       = 1'b1;
               hit_idx_in   = chk_idx_ff;
               hit_entry_in = rd_entry;
               chk_valid_in = 1'b0;
               state_in     = hct_pkg::FSM_DECIDE;
            end else if (chk_valid_ff &&
                         ({1'b0, chk_idx_ff} == hct_pkg::CNT_W'(fill_ff - hct_pkg::CNT_W'(1)))) begin
               chk_valid_in = 1'b0;
               state_in     = hct_pkg::FSM_DECIDE;
            end
         end

         hct_pkg::FSM_DECIDE: begin
            res_in       = '0;
            res_in.op_id = op_id_ff;
            state_in     = hct_pkg::FSM_FINISH;
            if (ovf_ff) begin
               res_in.status = hct_pkg::STATUS_OVERFLOW;
            end else if (req_ff.command == hct_pkg::CMD_ALLOC) begin
               alloc_count_in           = alloc_count_ff + 64'd1;
               res_in.zero_size_warning = req_ff.size == 64'd0;
               ram_wr_entry.freed       = 1'b0;
               ram_wr_entry.base        = req_ff.address;
               ram_wr_entry.length      = req_ff.size;
               ram_wr_entry.alloc_id    = op_id_ff;
               ram_wr_entry.release_id  = 64'd0;
               if (hit_ff) begin
                  ram_wr_en     = 1'b1;
                  ram_wr_addr   = hit_idx_ff;
                  res_in.status = hit_entry_ff.freed ? hct_pkg::STATUS_OK
                                                     : hct_pkg::STATUS_LIVE_REUSED;
               end else if (!table_full) begin
                  ram_wr_en     = 1'b1;
                  ram_wr_addr   = fill_ff[hct_pkg::IDX_W-1:0];
                  fill_in       = fill_ff + hct_pkg::CNT_W'(1);
                  res_in.status = hct_pkg::STATUS_OK;
               end else begin
                  res_in.status = hct_pkg::STATUS_TABLE_FULL;
               end
            end else begin
               release_count_in = release_count_ff + 64'd1;
               if (!hit_ff) begin
                  res_in.status = hct_pkg::STATUS_NOT_CHUNK;
               end else if (hit_entry_ff.base != req_ff.address) begin
                  res_in.status = hct_pkg::STATUS_INTERIOR;
               end else if (hit_entry_ff.freed) begin
                  res_in.status           = hct_pkg::STATUS_DOUBLE_FREE;
                  res_in.earlier_alloc_op = hit_entry_ff.alloc_id;
                  res_in.earlier_free_op  = hit_entry_ff.release_id;
               end else begin
                  res_in.status           = hct_pkg::STATUS_OK;
                  ram_wr_en               = 1'b1;
                  ram_wr_addr             = hit_idx_ff;
                  ram_wr_entry.freed      = 1'b1;
                  ram_wr_entry.release_id = op_id_ff;
               end
            end
            res_in.alloc_total   = alloc_count_in;
            res_in.release_total = release_count_in;
         end

         hct_pkg::FSM_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_data_in  = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = hct_pkg::FSM_IDLE;
            end
         end

         default: begin
            state_in = hct_pkg::FSM_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= hct_pkg::FSM_IDLE;
         alloc_count_ff   <= '0;
         release_count_ff <= '0;
         fill_ff          <= '0;
         scan_idx_ff      <= '0;
         chk_valid_ff     <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         alloc_count_ff   <= alloc_count_in;
         release_count_ff <= release_count_in;
         fill_ff          <= fill_in;
         scan_idx_ff      <= scan_idx_in;
         chk_valid_ff     <= chk_valid_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      chk_idx_ff   <= chk_idx_in;
      req_ff       <= req_in;
      op_id_ff     <= op_id_in;
      ovf_ff       <= ovf_in;
      hit_ff       <= hit_in;
      hit_idx_ff   <= hit_idx_in;
      hit_entry_ff <= hit_entry_in;
      res_ff       <= res_in;
      rsp_data_ff  <= rsp_data_in;
   end

endmodule

>>> sv/hct_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Holds the chunk table of the heap chunk tracker; depends on nothing.
module hct_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/hct_checker.sv
// Port-level checker for the heap chunk tracker, with its bind statement.
// Depends on hct_pkg and the heap_chunk_tracker top level.
module hct_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input hct_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input hct_pkg::rsp_type rsp_data
);

   // The block works on one item at a time.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req_ready stayed high after an item was accepted");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result item changed or vanished");

   // Every id that is not refused is the sum of both counters.
   a_id_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != hct_pkg::STATUS_OVERFLOW) |->
         rsp_data.op_id == rsp_data.alloc_total + rsp_data.release_total)
      else $error("op_id does not match the counter totals");

   a_earlier_ids: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != hct_pkg::STATUS_DOUBLE_FREE) |->
         (rsp_data.earlier_alloc_op == 64'd0) && (rsp_data.earlier_free_op == 64'd0))
      else $error("earlier ids reported without a double free");

endmodule

bind heap_chunk_tracker hct_checker u_hct_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
